/* sv/pch_pkg.sv */
// pch_pkg: shared constants, result codes and structs for the pc histogram counter
// no dependencies; imported by pch_ctrl, the top level and the checker

package pch_pkg;

	// table geometry
	localparam int INDEX_BITS = 11;
	localparam int TABLE_SIZE = 1 << INDEX_BITS;
	localparam int MAX_PROBES = 8;
	localparam int PROBE_W    = $clog2(MAX_PROBES + 1);

	// field widths
	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 11;
	localparam int ENTRY_W  = KEY_W + COUNT_W;

	// arithmetic constants
	localparam logic [KEY_W-1:0]   HASH_MULT        = 32'd2654435761;
	localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;
	localparam logic [KEY_W-1:0]   CODE_FLOOR_RESET = 32'h1000_0000;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_NOT_CODE = 3'd0,
		ST_HIT      = 3'd1,
		ST_HIT_SAT  = 3'd2,
		ST_NEW      = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	// one finished result from the probe controller
	typedef struct packed {
		status_t                 status;
		logic [INDEX_BITS-1:0]   slot;
		logic [COUNT_W-1:0]      count;
	} result_t;

	// table memory request from the probe controller
	typedef struct packed {
		logic                  wr_en;
		logic [INDEX_BITS-1:0] wr_addr;
		logic [ENTRY_W-1:0]    wr_data;
		logic                  rd_en;
		logic [INDEX_BITS-1:0] rd_addr;
	} ram_req_t;

endpackage

/* sv/pch_ram.sv */
// pch_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module pch_ram #(
	parameter int ADDR_W = 11,
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered, updated only while rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/pch_ctrl.sv */
// pch_ctrl: clearing sweep, hash and linear probe sequencer over the slot table
// depends on pch_pkg; drives the table memory through a ram_req_t struct

module pch_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [pch_pkg::KEY_W-1:0] sample_pc,
	input  logic [pch_pkg::KEY_W-1:0] min_code_addr,
	output logic                     res_valid,
	input  logic                     res_ready,
	output pch_pkg::result_t         res,
	output pch_pkg::ram_req_t        ram_req,
	input  logic [pch_pkg::ENTRY_W-1:0] rd_data
);

	import pch_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE,
		S_FINISH
	} state_t;

	state_t                state_q;
	logic [INDEX_BITS-1:0] clr_q;
	logic [KEY_W-1:0]      key_q;
	logic [INDEX_BITS-1:0] ptr_q;
	logic [PROBE_W-1:0]    issue_q;
	logic                  chk_s1;
	logic                  last_s1;
	logic [INDEX_BITS-1:0] addr_s1;
	result_t               res_q;

	logic [KEY_W-1:0]      prod;
	logic [INDEX_BITS-1:0] home;
	logic [KEY_W-1:0]      rd_key;
	logic [COUNT_W-1:0]    rd_cnt;
	logic                  issue;
	logic                  hit_free;
	logic                  hit_match;

	// multiplicative hash, low word kept, top index bits give the home slot
	assign prod = key_q * HASH_MULT;
	assign home = prod[KEY_W-1 -: INDEX_BITS];

	// returning slot entry and probe decisions
	assign rd_key    = rd_data[ENTRY_W-1 -: KEY_W];
	assign rd_cnt    = rd_data[COUNT_W-1:0];
	assign issue     = (state_q == S_PROBE) && (issue_q != PROBE_W'(MAX_PROBES));
	assign hit_free  = chk_s1 && (rd_cnt == '0);
	assign hit_match = chk_s1 && (rd_cnt != '0) && (rd_key == key_q);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FINISH);
	assign res       = res_q;

	// table memory requests: clearing writes, probe reads, update write-back
	always_comb begin
		ram_req = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = clr_q;
			end
			S_PROBE: begin
				ram_req.rd_en   = issue;
				ram_req.rd_addr = ptr_q;
				ram_req.wr_addr = addr_s1;
				if (hit_free) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_data = {key_q, COUNT_W'(1)};
				end else if (hit_match && (rd_cnt != COUNT_MAX)) begin
					ram_req.wr_en   = 1'b1;
					ram_req.wr_data = {key_q, rd_cnt + COUNT_W'(1)};
				end
			end
			S_IDLE, S_HASH, S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			key_q   <= '0;
			ptr_q   <= '0;
			issue_q <= '0;
			chk_s1  <= 1'b0;
			last_s1 <= 1'b0;
			addr_s1 <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + INDEX_BITS'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						key_q   <= {sample_pc[KEY_W-1:1], 1'b0};
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					chk_s1  <= 1'b0;
					issue_q <= '0;
					ptr_q   <= home;
					if (key_q < min_code_addr) begin
						res_q   <= '{status: ST_NOT_CODE, slot: '0, count: '0};
						state_q <= S_FINISH;
					end else begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					// one read issued per cycle, its entry checked the next cycle
					chk_s1  <= issue;
					addr_s1 <= ptr_q;
					last_s1 <= (issue_q == PROBE_W'(MAX_PROBES - 1));
					if (issue) begin
						ptr_q   <= ptr_q + INDEX_BITS'(1);
						issue_q <= issue_q + PROBE_W'(1);
					end
					priority if (hit_free) begin
						res_q   <= '{status: ST_NEW, slot: addr_s1, count: COUNT_W'(1)};
						state_q <= S_FINISH;
					end else if (hit_match) begin
						if (rd_cnt == COUNT_MAX) begin
							res_q <= '{status: ST_HIT_SAT, slot: addr_s1, count: rd_cnt};
						end else begin
							res_q <= '{status: ST_HIT, slot: addr_s1,
								count: rd_cnt + COUNT_W'(1)};
						end
						state_q <= S_FINISH;
					end else if (chk_s1 && last_s1) begin
						res_q   <= '{status: ST_FULL, slot: '0, count: '0};
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/pc_histogram_hash_counter_unit.sv */
// Program-counter histogram counter. Each sample_pc beat (bit 0 ignored) is hashed into a
// 2048-slot table and counted with linear probing over up to 8 slots; one result beat comes
// back per sample with the slot, its count and running sample and drop totals. After reset the
// table is swept clear, one slot per cycle, during which in_ready stays low; min_code_addr
// writes are taken at any time. An address below min_code_addr is dropped without probing;
// a probed sample reads its slots from the table memory, which returns one slot per cycle on
// its single read port. A new sample is taken while the previous result still waits in the
// output register.
// depends on pch_pkg, pch_ram and pch_ctrl

module pc_histogram_hash_counter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pch_pkg::KEY_W-1:0]    sample_pc,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pch_pkg::STATUS_W-1:0] status,
	output logic [pch_pkg::SLOT_W-1:0]   slot_index,
	output logic [pch_pkg::COUNT_W-1:0]  slot_count,
	output logic [pch_pkg::KEY_W-1:0]    total_samples,
	output logic [pch_pkg::KEY_W-1:0]    dropped_samples,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pch_pkg::KEY_W-1:0]    min_code_addr
);

	import pch_pkg::*;

	logic [KEY_W-1:0]   min_code_q;
	logic               out_valid_q;
	result_t            out_res_q;
	logic [KEY_W-1:0]   total_q;
	logic [KEY_W-1:0]   drop_q;

	logic               res_valid;
	logic               res_ready;
	result_t            res;
	ram_req_t           ram_req;
	logic [ENTRY_W-1:0] rd_data;
	logic               take;
	logic               dropped;

	// code floor register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_q <= CODE_FLOOR_RESET;
		end else if (cfg_valid) begin
			min_code_q <= min_code_addr;
		end
	end

	// slot table: key in the upper bits, count in the lower
	pch_ram #(
		.ADDR_W (INDEX_BITS),
		.DATA_W (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (rd_data)
	);

	pch_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_pc     (sample_pc),
		.min_code_addr (min_code_q),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.ram_req       (ram_req),
		.rd_data       (rd_data)
	);

	// output register with running totals, loaded when empty or being drained
	assign res_ready = !out_valid_q || out_ready;
	assign take      = res_valid && res_ready;
	assign dropped   = (res.status == ST_NOT_CODE) || (res.status == ST_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
			total_q     <= '0;
			drop_q      <= '0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				out_res_q   <= res;
				total_q     <= total_q + KEY_W'(1);
				drop_q      <= drop_q + KEY_W'(dropped);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_res_q.status;
	assign slot_index      = SLOT_W'(out_res_q.slot);
	assign slot_count      = out_res_q.count;
	assign total_samples   = total_q;
	assign dropped_samples = drop_q;

endmodule

/* sv/pch_checker.sv */
// pch_checker: port-level assertions for the pc histogram counter, bound to the top level
// depends on pch_pkg and pc_histogram_hash_counter_unit

module pch_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [pch_pkg::STATUS_W-1:0] status,
	input logic [pch_pkg::SLOT_W-1:0]   slot_index,
	input logic [pch_pkg::COUNT_W-1:0]  slot_count
);

	import pch_pkg::*;

	// a waiting result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_count))
		else $error("result beat changed while stalled");

	// one sample at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

	// dropped samples report no slot and no count
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_CODE || status == ST_FULL)
		|-> slot_index == '0 && slot_count == '0)
		else $error("dropped sample with slot or count");

	// a claimed slot starts at one
	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NEW |-> slot_count == COUNT_W'(1))
		else $error("new entry count not one");

	// any hit is above one, a saturated hit sits at the ceiling
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_HIT_SAT || status == ST_HIT)
		|-> slot_count > COUNT_W'(1) && (status != ST_HIT_SAT || slot_count == COUNT_MAX))
		else $error("hit count out of place");

endmodule

bind pc_histogram_hash_counter_unit pch_checker u_pch_checker (.*);
